@@ rtl/owbm_pkg.sv @@
// ============================================================================
// owbm_pkg: shared types and constants of the one-wire bus master
// Item payloads, the classified queue entry, the timing register set and
// its reset values, and the register index codes.
// ============================================================================
`default_nettype none

package owbm_pkg;

    // Width of one timing register
    localparam int unsigned CFG_W = 10;

    // Fixed length of the tail after each read sample
    localparam logic [CFG_W-1:0] READ_TAIL_TICKS = 10'd50;

    // Command codes carried by an input item
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // Timing register index codes
    typedef enum logic [2:0] {
        REG_RESET_LOW    = 3'd0,
        REG_PRES_DELAY   = 3'd1,
        REG_RESET_TAIL   = 3'd2,
        REG_WR_ONE_LOW   = 3'd3,
        REG_WR_ZERO_LOW  = 3'd4,
        REG_WR_SLOT      = 3'd5,
        REG_RD_LOW       = 3'd6,
        REG_RD_SMP_DELAY = 3'd7
    } t_reg_idx;

    // Input item: one microsecond tick
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] tx_byte;
        logic       line_in;
    } t_in;

    // Result item: bus drive and status for the tick
    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] rx_byte;
    } t_res;

    // Classified tick as held in the queue
    typedef struct packed {
        t_op        op;
        logic [7:0] tx_byte;
        logic       line_in;
    } t_entry;

    // Timing register set
    typedef struct packed {
        logic [CFG_W-1:0] reset_low_time;
        logic [CFG_W-1:0] presence_delay;
        logic [CFG_W-1:0] reset_tail_time;
        logic [CFG_W-1:0] write_one_low;
        logic [CFG_W-1:0] write_zero_low;
        logic [CFG_W-1:0] write_slot_time;
        logic [CFG_W-1:0] read_low_time;
        logic [CFG_W-1:0] read_sample_delay;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        reset_low_time:    10'd480,
        presence_delay:    10'd70,
        reset_tail_time:   10'd410,
        write_one_low:     10'd6,
        write_zero_low:    10'd60,
        write_slot_time:   10'd70,
        read_low_time:     10'd4,
        read_sample_delay: 10'd8
    };

endpackage

`default_nettype wire

@@ rtl/owbm_front.sv @@
// ============================================================================
// owbm_front: input side of the bus master
// Accepts tick items, decodes the command field and pushes the classified
// tick into the queue; stalls the sender while the queue is full.
// ============================================================================
`default_nettype none

module owbm_front (
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  owbm_pkg::t_in        i_in_data,
    input  wire logic            i_q_full,
    output logic                 o_push,
    output owbm_pkg::t_entry     o_entry
);

    // Hold the sender off while the queue has no room
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid & ~i_q_full;

    // Decode the command and pass the line sample and data along
    always_comb begin
        o_entry.tx_byte = i_in_data.tx_byte;
        o_entry.line_in = i_in_data.line_in;
        case (i_in_data.cmd)
            owbm_pkg::OP_RESET: o_entry.op = owbm_pkg::OP_RESET;
            owbm_pkg::OP_WRITE: o_entry.op = owbm_pkg::OP_WRITE;
            owbm_pkg::OP_READ:  o_entry.op = owbm_pkg::OP_READ;
            default:            o_entry.op = owbm_pkg::OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/owbm_queue.sv @@
// ============================================================================
// owbm_queue: short queue between the front and the timing engine
// Register based FIFO of classified ticks; push and pop may share a cycle.
// ============================================================================
`default_nettype none

module owbm_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  owbm_pkg::t_entry     i_entry,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output owbm_pkg::t_entry     o_entry
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    owbm_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    // Advance the pointers with wrap and track the fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

@@ rtl/owbm_engine.sv @@
// ============================================================================
// owbm_engine: timing engine of the bus master
// Runs the reset, write and read sequences one tick per popped item and
// registers the result of each tick in the output stage.
// ============================================================================
`default_nettype none

module owbm_engine (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  owbm_pkg::t_cfg       i_cfg,
    input  wire logic            i_q_valid,
    input  owbm_pkg::t_entry     i_q_entry,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output owbm_pkg::t_res       o_out_data
);

    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_RST_LOW  = 8'b0000_0010,
        PH_RST_WAIT = 8'b0000_0100,
        PH_RST_TAIL = 8'b0000_1000,
        PH_WR_SLOT  = 8'b0001_0000,
        PH_RD_LOW   = 8'b0010_0000,
        PH_RD_WAIT  = 8'b0100_0000,
        PH_RD_TAIL  = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [10:0] cnt;
        logic [2:0]  bidx;
        logic [7:0]  sh;
        logic        pres;
        logic [7:0]  rres;
    } t_st;

    typedef struct packed {
        t_st  st;
        logic done;
    } t_step;

    // Length of the running phase
    function automatic logic [owbm_pkg::CFG_W-1:0] f_len(t_phase p, owbm_pkg::t_cfg c);
        logic [owbm_pkg::CFG_W-1:0] len;
        case (p)
            PH_RST_LOW:  len = c.reset_low_time;
            PH_RST_WAIT: len = c.presence_delay;
            PH_RST_TAIL: len = c.reset_tail_time;
            PH_WR_SLOT:  len = c.write_slot_time;
            PH_RD_LOW:   len = c.read_low_time;
            PH_RD_WAIT:  len = c.read_sample_delay;
            PH_RD_TAIL:  len = owbm_pkg::READ_TAIL_TICKS;
            default:     len = '0;
        endcase
        return len;
    endfunction

    // Close the running phase if its time has run out
    function automatic t_step f_end(t_step s, logic line, owbm_pkg::t_cfg c);
        t_step                      r;
        logic [owbm_pkg::CFG_W-1:0] len;
        r   = s;
        len = f_len(s.st.phase, c);
        if (s.st.phase != PH_IDLE && s.st.cnt >= {1'b0, len}) begin
            r.st.cnt = '0;
            case (s.st.phase)
                PH_RST_LOW: begin
                    r.st.phase = PH_RST_WAIT;
                end
                PH_RST_WAIT: begin
                    r.st.pres  = ~line;
                    r.st.phase = PH_RST_TAIL;
                end
                PH_RST_TAIL: begin
                    r.st.phase = PH_IDLE;
                    r.done     = 1'b1;
                end
                PH_WR_SLOT: begin
                    if (len == '0) begin
                        // zero-length slots: every remaining bit ends now
                        r.st.sh    = '0;
                        r.st.bidx  = '0;
                        r.st.phase = PH_IDLE;
                        r.done     = 1'b1;
                    end else begin
                        r.st.sh = {1'b0, s.st.sh[7:1]};
                        if (s.st.bidx == 3'd7) begin
                            r.st.bidx  = '0;
                            r.st.phase = PH_IDLE;
                            r.done     = 1'b1;
                        end else begin
                            r.st.bidx = s.st.bidx + 3'd1;
                        end
                    end
                end
                PH_RD_LOW: begin
                    r.st.phase = PH_RD_WAIT;
                end
                PH_RD_WAIT: begin
                    r.st.sh    = {line, s.st.sh[7:1]};
                    r.st.phase = PH_RD_TAIL;
                end
                PH_RD_TAIL: begin
                    if (s.st.bidx == 3'd7) begin
                        r.st.bidx  = '0;
                        r.st.rres  = s.st.sh;
                        r.st.phase = PH_IDLE;
                        r.done     = 1'b1;
                    end else begin
                        r.st.bidx  = s.st.bidx + 3'd1;
                        r.st.phase = PH_RD_LOW;
                    end
                end
                default: begin
                    r.st.phase = PH_IDLE;
                end
            endcase
        end
        return r;
    endfunction

    t_st               r_st, n_st;
    owbm_pkg::t_res    r_out, n_out;
    logic              r_out_valid;
    logic              fire;
    t_step             s0, s1, s2, s3;
    logic [owbm_pkg::CFG_W-1:0] wr_low;

    // Take a tick when the output stage is free or being drained
    assign fire        = i_q_valid & (~r_out_valid | ~i_out_stall);
    assign o_q_pop     = fire;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Start a command when idle, then close up to three expired phases
    always_comb begin
        s0.st   = r_st;
        s0.done = 1'b0;
        if (r_st.phase == PH_IDLE) begin
            case (i_q_entry.op)
                owbm_pkg::OP_RESET: begin
                    s0.st.cnt   = '0;
                    s0.st.bidx  = '0;
                    s0.st.phase = PH_RST_LOW;
                end
                owbm_pkg::OP_WRITE: begin
                    s0.st.cnt   = '0;
                    s0.st.bidx  = '0;
                    s0.st.sh    = i_q_entry.tx_byte;
                    s0.st.phase = PH_WR_SLOT;
                end
                owbm_pkg::OP_READ: begin
                    s0.st.cnt   = '0;
                    s0.st.bidx  = '0;
                    s0.st.sh    = '0;
                    s0.st.phase = PH_RD_LOW;
                end
                default: begin
                end
            endcase
        end
        s1 = f_end(s0, i_q_entry.line_in, i_cfg);
        s2 = f_end(s1, i_q_entry.line_in, i_cfg);
        s3 = f_end(s2, i_q_entry.line_in, i_cfg);
    end

    // Drive the line and advance the tick counter
    always_comb begin
        wr_low = s3.st.sh[0] ? i_cfg.write_one_low : i_cfg.write_zero_low;
        case (s3.st.phase)
            PH_RST_LOW, PH_RD_LOW: n_out.drive_low = 1'b1;
            PH_WR_SLOT:            n_out.drive_low = (s3.st.cnt < {1'b0, wr_low});
            default:               n_out.drive_low = 1'b0;
        endcase
        n_st = s3.st;
        if (s3.st.phase != PH_IDLE && s3.st.cnt != '1) begin
            n_st.cnt = s3.st.cnt + 11'd1;
        end
        n_out.busy_res = (s3.st.phase != PH_IDLE);
        n_out.done_res = s3.done;
        n_out.presence = s3.st.pres;
        n_out.rx_byte  = s3.st.rres;
    end

    // Sequencer state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.phase  <= PH_IDLE;
            r_st.cnt    <= '0;
            r_st.bidx   <= '0;
            r_st.sh     <= '0;
            r_st.pres   <= 1'b0;
            r_st.rres   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_st        <= n_st;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

@@ rtl/one_wire_bus_master_top.sv @@
// ============================================================================
// one_wire_bus_master_top: one-wire bus master
// Each input item is one microsecond tick with an optional command and the
// sampled bus level; each result item gives the bus drive and status.
//
//   channel   direction  handshake          payload
//   in        input      valid / stall      t_in  (cmd, tx_byte, line_in)
//   out       output     valid / stall      t_res (drive_low .. rx_byte)
//   cfg       input      valid / ready      3-bit index, 10-bit data
//
// One item per clock cycle sustained while the output is not stalled;
// the timing engine evaluates each tick combinationally, any zero-length
// phases included. Ticks are registered in the queue, then the output register.
// Reset is synchronous; it clears the queue, the engine and restores the
// timing registers to their defaults. No clearing pass.
// An output stall holds the result register; the queue then fills and the
// input stall rises once it is full. Config writes are always taken.
// ============================================================================
`default_nettype none

module one_wire_bus_master_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  owbm_pkg::t_in        i_in_data,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output owbm_pkg::t_res       o_out_data,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [2:0]      i_cfg_index,
    input  wire logic [owbm_pkg::CFG_W-1:0] i_cfg_data
);

    owbm_pkg::t_cfg   r_cfg;
    owbm_pkg::t_entry push_entry, head_entry;
    logic             push, q_full, q_valid, q_pop;

    // Timing register file
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= owbm_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            case (owbm_pkg::t_reg_idx'(i_cfg_index))
                owbm_pkg::REG_RESET_LOW:    r_cfg.reset_low_time    <= i_cfg_data;
                owbm_pkg::REG_PRES_DELAY:   r_cfg.presence_delay    <= i_cfg_data;
                owbm_pkg::REG_RESET_TAIL:   r_cfg.reset_tail_time   <= i_cfg_data;
                owbm_pkg::REG_WR_ONE_LOW:   r_cfg.write_one_low     <= i_cfg_data;
                owbm_pkg::REG_WR_ZERO_LOW:  r_cfg.write_zero_low    <= i_cfg_data;
                owbm_pkg::REG_WR_SLOT:      r_cfg.write_slot_time   <= i_cfg_data;
                owbm_pkg::REG_RD_LOW:       r_cfg.read_low_time     <= i_cfg_data;
                owbm_pkg::REG_RD_SMP_DELAY: r_cfg.read_sample_delay <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Accept and classify ticks
    owbm_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    // Decouple front and engine
    owbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    // Run the bus sequences
    owbm_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_entry   (head_entry),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
